### hdl/plc_pkg.sv
// Shared constants, payload types and constant tables for the power-law compander.
// No dependencies; every other file of the block imports this package.
package plc_pkg;

	// Field formats
	localparam int SAMPLE_BITS     = 24;  // signed Q1.(SAMPLE_BITS-1)
	localparam int EXP_BITS        = 16;  // exponent register width
	localparam int EXP_FRAC_BITS   = 12;  // exponent fraction bits
	localparam int LOG_TAB_ENTRIES = 256;
	localparam int LOG_IDX_BITS    = $clog2(LOG_TAB_ENTRIES);
	localparam int LOG_FRAC_BITS   = 16;  // log2 value is Q.16
	localparam int ROOT_FRAC_BITS  = 30;  // mantissa of exp2 is Q.30

	localparam logic signed [EXP_BITS-1:0] CFG_EXP_RESET = 16'sd3699;  // log10(8)

	// Derived widths
	localparam int E_IDX_BITS  = $clog2(SAMPLE_BITS);          // leading-one position
	localparam int E_BITS      = E_IDX_BITS + 1;               // signed integer part of log2
	localparam int L_BITS      = E_BITS + LOG_FRAC_BITS;       // signed log2 magnitude
	localparam int P_BITS      = L_BITS + EXP_BITS;            // log2 * exponent
	localparam int Y_BITS      = P_BITS + 1 - EXP_FRAC_BITS;   // rounded Q.16 result
	localparam int I_BITS      = Y_BITS - LOG_FRAC_BITS;       // integer part of y
	localparam int ROOT_STAGES = LOG_FRAC_BITS;
	localparam int ROOT_SHIFT  = ROOT_FRAC_BITS - (SAMPLE_BITS - 1);
	localparam int SHAMT_MAX   = ROOT_FRAC_BITS + 2;           // any larger shift gives zero
	localparam int SHAMT_BITS  = $clog2(SHAMT_MAX + 1);
	localparam int MAG_BITS    = ROOT_FRAC_BITS + 3;

	// Payload between log and scale sections
	typedef struct packed {
		logic                     neg;
		logic                     zero;
		logic signed [L_BITS-1:0] l;
	} log_t;

	// Payload through the exp2 sections
	typedef struct packed {
		logic                     neg;
		logic                     zero;
		logic                     ypos;
		logic                     yzero;
		logic [SHAMT_BITS-1:0]    shamt;
		logic [LOG_FRAC_BITS-1:0] r;
		logic [ROOT_FRAC_BITS:0]  fm;
	} exp_t;

	typedef logic [LOG_FRAC_BITS-1:0] log_tab_t [LOG_TAB_ENTRIES];
	typedef logic [63:0]              root_tab_t [ROOT_STAGES+1];

	// log2(1 + idx/entries) in Q.16, truncated, by repeated squaring
	function automatic logic [LOG_FRAC_BITS-1:0] log_entry(input int unsigned idx);
		logic [63:0]              v;
		logic [LOG_FRAC_BITS-1:0] r;
		v = ((64'(LOG_TAB_ENTRIES) + 64'(idx)) << ROOT_FRAC_BITS) / 64'(LOG_TAB_ENTRIES);
		r = '0;
		for (int k = 0; k < LOG_FRAC_BITS; k++) begin
			v = (v * v) >> ROOT_FRAC_BITS;
			r = {r[LOG_FRAC_BITS-2:0], 1'b0};
			if (v >= (64'd2 << ROOT_FRAC_BITS)) begin
				r[0] = 1'b1;
				v    = v >> 1;
			end
		end
		return r;
	endfunction

	function automatic log_tab_t build_log_tab();
		log_tab_t t;
		for (int i = 0; i < LOG_TAB_ENTRIES; i++) begin
			t[i] = log_entry(i);
		end
		return t;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = val;
		res = '0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// R_k = 2^(2^-k) in Q.30, each a truncated square root of the one before
	function automatic root_tab_t build_root_tab();
		root_tab_t t;
		t[0] = 64'd2 << ROOT_FRAC_BITS;
		for (int k = 1; k <= ROOT_STAGES; k++) begin
			t[k] = isqrt64(t[k-1] << ROOT_FRAC_BITS);
		end
		return t;
	endfunction

	localparam log_tab_t  LOG_TAB  = build_log_tab();
	localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

### hdl/plc_if.sv
// Valid/ready stream interfaces for the compander's sample and result channels.
// Depends on plc_pkg for the sample width.
interface plc_in_if import plc_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface plc_out_if import plc_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

### hdl/plc_log.sv
// Log2 front end: magnitude, leading-one search, normalize, table lookup (stages 1-4).
// Depends on plc_pkg (widths, log_t, LOG_TAB).
module plc_log import plc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                          up_en,
	output logic                          out_vld,
	output log_t                          out_data,
	input  logic                          dn_en
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic                    neg_s1, zero_s1;
	logic [SAMPLE_BITS-1:0]  m_s1;
	logic                    neg_s2, zero_s2;
	logic [SAMPLE_BITS-1:0]  m_s2;
	logic [E_IDX_BITS-1:0]   e_s2;
	logic                    neg_s3, zero_s3;
	logic [E_IDX_BITS-1:0]   e_s3;
	logic [LOG_IDX_BITS-1:0] idx_s3;
	log_t                    data_s4;

	logic [E_IDX_BITS-1:0]   e_c;
	logic [SAMPLE_BITS-1:0]  mn_c;
	logic [E_BITS-1:0]       expo_c;

	// a stage loads when empty or when its content moves on
	assign en4   = ~v_s4 | dn_en;
	assign en3   = ~v_s3 | en4;
	assign en2   = ~v_s2 | en3;
	assign en1   = ~v_s1 | en2;
	assign up_en = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_vld;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// leading-one position
	always_comb begin
		e_c = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (m_s1[i]) e_c = E_IDX_BITS'(i);
		end
	end

	assign mn_c   = m_s2 << (E_IDX_BITS'(SAMPLE_BITS - 1) - e_s2);
	assign expo_c = E_BITS'(e_s3) - E_BITS'(SAMPLE_BITS - 1);

	always_ff @(posedge clk) begin
		if (en1 && in_vld) begin
			neg_s1  <= in_sample[SAMPLE_BITS-1];
			zero_s1 <= (in_sample == '0);
			m_s1    <= in_sample[SAMPLE_BITS-1] ? (~in_sample + 1'b1) : in_sample;
		end
		if (en2 && v_s1) begin
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			m_s2    <= m_s1;
			e_s2    <= e_c;
		end
		if (en3 && v_s2) begin
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			e_s3    <= e_s2;
			idx_s3  <= mn_c[SAMPLE_BITS-2 -: LOG_IDX_BITS];
		end
		if (en4 && v_s3) begin
			data_s4.neg  <= neg_s3;
			data_s4.zero <= zero_s3;
			data_s4.l    <= {expo_c, LOG_TAB[idx_s3]};
		end
	end

	assign out_vld  = v_s4;
	assign out_data = data_s4;

endmodule

### hdl/plc_scale.sv
// Exponent multiply and Q.16 rounding/classification (stages 5-6).
// Depends on plc_pkg (log_t, exp_t, widths).
module plc_scale import plc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [EXP_BITS-1:0] curve_exponent,
	input  logic                       in_vld,
	input  log_t                       in_data,
	output logic                       up_en,
	output logic                       out_vld,
	output exp_t                       out_data,
	input  logic                       dn_en
);

	logic v_s5, v_s6;
	logic en5, en6;

	logic                     neg_s5, zero_s5;
	logic signed [P_BITS-1:0] prod_s5;
	exp_t                     data_s6;

	logic signed [P_BITS-1:0]   prod_c;
	logic signed [P_BITS:0]     q_c;
	logic signed [Y_BITS-1:0]   y_c;
	logic signed [I_BITS:0]     n_c;
	logic signed [I_BITS+1:0]   sfull_c;
	logic [SHAMT_BITS-1:0]      shamt_c;

	assign en6   = ~v_s6 | dn_en;
	assign en5   = ~v_s5 | en6;
	assign up_en = en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en5) v_s5 <= in_vld;
			if (en6) v_s6 <= v_s5;
		end
	end

	assign prod_c = $signed(in_data.l) * $signed(curve_exponent);

	// round half up to Q.16: arithmetic shift gives floor for either sign
	assign q_c = $signed({prod_s5[P_BITS-1], prod_s5})
	             + $signed((P_BITS+1)'(1) << (EXP_FRAC_BITS - 1));
	assign y_c = q_c[P_BITS:EXP_FRAC_BITS];

	// integer part I = floor(y / 2^16); right shift is ROOT_SHIFT - I
	assign n_c     = -$signed({y_c[Y_BITS-1], y_c[Y_BITS-1:LOG_FRAC_BITS]});
	assign sfull_c = $signed((I_BITS+2)'(ROOT_SHIFT)) + $signed({n_c[I_BITS], n_c});
	assign shamt_c = (sfull_c > $signed((I_BITS+2)'(SHAMT_MAX))) ? SHAMT_BITS'(SHAMT_MAX)
	                 : sfull_c[SHAMT_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en5 && in_vld) begin
			neg_s5  <= in_data.neg;
			zero_s5 <= in_data.zero;
			prod_s5 <= prod_c;
		end
		if (en6 && v_s5) begin
			data_s6.neg   <= neg_s5;
			data_s6.zero  <= zero_s5;
			data_s6.ypos  <= ~y_c[Y_BITS-1] & (y_c != '0);
			data_s6.yzero <= (y_c == '0);
			data_s6.shamt <= shamt_c;
			data_s6.r     <= y_c[LOG_FRAC_BITS-1:0];
			data_s6.fm    <= (ROOT_FRAC_BITS+1)'(1) << ROOT_FRAC_BITS;
		end
	end

	assign out_vld  = v_s6;
	assign out_data = data_s6;

endmodule

### hdl/plc_exp.sv
// Exp2 of the fraction: one stage per fraction bit, each a truncated Q.30 root multiply.
// Depends on plc_pkg (exp_t, ROOT_TAB).
module plc_exp import plc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  exp_t in_data,
	output logic up_en,
	output logic out_vld,
	output exp_t out_data,
	input  logic dn_en
);

	logic [ROOT_STAGES-1:0] vld_s;
	exp_t                   dat_s [ROOT_STAGES];
	logic [ROOT_STAGES:0]   en;

	assign en[ROOT_STAGES] = dn_en;

	for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
		exp_t                          src;
		logic                          src_vld;
		logic [2*ROOT_FRAC_BITS+1:0]   prod;
		exp_t                          nxt;

		if (k == 0) begin : g_first
			assign src     = in_data;
			assign src_vld = in_vld;
		end else begin : g_next
			assign src     = dat_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		assign en[k] = ~vld_s[k] | en[k+1];
		assign prod  = src.fm * ROOT_TAB[k+1][ROOT_FRAC_BITS:0];

		// fraction bit of weight 2^-(k+1)
		always_comb begin
			nxt = src;
			if (src.r[LOG_FRAC_BITS-1-k]) begin
				nxt.fm = prod[ROOT_FRAC_BITS +: ROOT_FRAC_BITS+1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && src_vld) begin
				dat_s[k] <= nxt;
			end
		end
	end

	assign up_en    = en[0];
	assign out_vld  = vld_s[ROOT_STAGES-1];
	assign out_data = dat_s[ROOT_STAGES-1];

endmodule

### hdl/power_law_compander.sv
// Top level of the power-law compander: exponent register, pipeline sections, output stage.
// Depends on plc_pkg, plc_if, plc_log, plc_scale, plc_exp.
//
//   channel   dir  payload                          transfer
//   in_ch     in   sample_in  (24b signed Q1.23)    valid & ready
//   out_ch    out  sample_out (24b signed), clipped valid & ready
//   cfg       in   cfg_wdata  (16b signed Q4.12)    cfg_we, no handshake
//
// One request enters per clock while out_ch is not stalled.
// The depth is set by the 16 root-multiply stages of the exp2 section plus 4 log,
// 2 scale and 1 output stage. Every stage carries a valid bit and loads when it is
// empty or its content moves on, so bubbles collapse and a stall loses nothing.
// arst_n clears all valid bits and sets the exponent to log10(8).
module power_law_compander import plc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic signed [EXP_BITS-1:0] cfg_wdata,
	plc_in_if.sink                     in_ch,
	plc_out_if.source                  out_ch
);

	// exponent p, signed Q4.12
	logic signed [EXP_BITS-1:0] curve_exponent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_exponent_q <= CFG_EXP_RESET;
		end else if (cfg_we) begin
			curve_exponent_q <= cfg_wdata;
		end
	end

	// section links
	logic log_vld;
	log_t log_data;
	logic scl_vld, scl_en;
	exp_t scl_data;
	logic exp_vld, exp_en;
	exp_t exp_data;
	logic en_out;

	// log2|x| as signed Q.16
	plc_log u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (in_ch.valid),
		.in_sample (in_ch.sample_in),
		.up_en     (in_ch.ready),
		.out_vld   (log_vld),
		.out_data  (log_data),
		.dn_en     (scl_en)
	);

	// y = round(L * p), split into integer shift and fraction bits
	plc_scale u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.curve_exponent (curve_exponent_q),
		.in_vld         (log_vld),
		.in_data        (log_data),
		.up_en          (scl_en),
		.out_vld        (scl_vld),
		.out_data       (scl_data),
		.dn_en          (exp_en)
	);

	// 2^frac(y) in Q.30
	plc_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (scl_vld),
		.in_data  (scl_data),
		.up_en    (exp_en),
		.out_vld  (exp_vld),
		.out_data (exp_data),
		.dn_en    (en_out)
	);

	// ---------------------------------------------------------------
	// Output stage (stage 23): rounding shift, saturation, sign.
	// ---------------------------------------------------------------
	logic                          out_vld_s23;
	logic signed [SAMPLE_BITS-1:0] out_sample_s23;
	logic                          out_clip_s23;

	logic [MAG_BITS-1:0]    rnd_c;
	logic [MAG_BITS-1:0]    sum_c;
	logic [MAG_BITS-1:0]    mag_c;
	logic [MAG_BITS-1:0]    limit_c;
	logic [MAG_BITS-1:0]    sat_c;
	logic                   clip_c;
	logic [SAMPLE_BITS-1:0] res_c;

	localparam logic [MAG_BITS-1:0] FULL = MAG_BITS'(1) << (SAMPLE_BITS - 1);

	assign en_out = ~out_vld_s23 | out_ch.ready;

	always_comb begin
		// half-up rounding of the Q.30 mantissa down to the sample grid
		rnd_c = (exp_data.shamt == '0) ? '0 : (MAG_BITS'(1) << (exp_data.shamt - 1'b1));
		sum_c = MAG_BITS'(exp_data.fm) + rnd_c;
		// negative full scale is reachable, positive stops one code short
		limit_c = exp_data.neg ? FULL : FULL - 1'b1;
		if (exp_data.zero) begin
			mag_c = '0;
		end else if (exp_data.ypos) begin
			mag_c = limit_c + 1'b1;        // above full scale
		end else if (exp_data.yzero) begin
			mag_c = FULL;                  // exactly full scale
		end else begin
			mag_c = sum_c >> exp_data.shamt;
		end
		clip_c = (mag_c > limit_c);
		sat_c  = clip_c ? limit_c : mag_c;
		res_c  = exp_data.neg ? (~sat_c[SAMPLE_BITS-1:0] + 1'b1) : sat_c[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s23 <= 1'b0;
		end else if (en_out) begin
			out_vld_s23 <= exp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && exp_vld) begin
			out_sample_s23 <= res_c;
			out_clip_s23   <= clip_c;
		end
	end

	assign out_ch.valid      = out_vld_s23;
	assign out_ch.sample_out = out_sample_s23;
	assign out_ch.clipped    = out_clip_s23;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------

	// an empty output register means the whole ready chain is open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_s23 |-> in_ch.ready)
		else $error("input not ready while output stage is empty");

	// a stalled exp2 result stays put until the output stage takes it
	a_exp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		exp_vld && !en_out |=> exp_vld && $stable(exp_data))
		else $error("exp2 result changed while stalled");

	// a clipped result sits on one of the rails
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.clipped |->
			(out_ch.sample_out == $signed(FULL[SAMPLE_BITS-1:0] - 1'b1)) ||
			(out_ch.sample_out == $signed(FULL[SAMPLE_BITS-1:0])))
		else $error("clipped flag on a result that is not at full scale");

endmodule

### dv/power_law_compander_tb.sv
// Self-checking testbench for the power-law compander: directed and random samples
// over several exponent settings, each result checked against a behavioral compander.
// Depends on plc_pkg, plc_if and power_law_compander.
`timescale 1ns / 100ps

module power_law_compander_tb import plc_pkg::*; ();

	// Result latency given for the block; the end pause is based on it.
	localparam int PIPE_LATENCY   = 23;
	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no request or result moving
	localparam int MAX_REPORTS    = 10;

	localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [EXP_BITS-1:0]    EXP_MAX  = {1'b0, {(EXP_BITS-1){1'b1}}};
	localparam logic signed [EXP_BITS-1:0]    EXP_MIN  = {1'b1, {(EXP_BITS-1){1'b0}}};
	localparam logic signed [EXP_BITS-1:0]    EXP_UNITY = EXP_BITS'(1 << EXP_FRAC_BITS);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          clip;
	} companded_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic signed [EXP_BITS-1:0] cfg_wdata;

	plc_in_if  in_ch();
	plc_out_if out_ch();

	power_law_compander dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// Exponent as the block holds it; tracks every register write.
	logic signed [EXP_BITS-1:0] exponent_reg = CFG_EXP_RESET;

	// log2(1 + i/entries) in Q.16 and roots 2^(2^-k) in Q.30, built at time zero.
	longint unsigned log_curve [LOG_TAB_ENTRIES];
	longint unsigned root_curve [LOG_FRAC_BITS+1];

	companded_t pending_outputs[$];   // expected results, oldest first
	int         mismatch_count = 0;
	int         idle_cycles    = 0;
	bit         gaps_on        = 1'b1; // random idling on both channels

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void build_curve_tables();
		longint unsigned v;
		longint unsigned acc;
		longint unsigned trial;
		longint unsigned bits_acc;
		for (int i = 0; i < LOG_TAB_ENTRIES; i++) begin
			// Square repeatedly; every time the value passes 2 a result bit is set.
			v        = (64'(LOG_TAB_ENTRIES + i) << ROOT_FRAC_BITS) / LOG_TAB_ENTRIES;
			bits_acc = 0;
			for (int k = 0; k < LOG_FRAC_BITS; k++) begin
				v        = (v * v) >> ROOT_FRAC_BITS;
				bits_acc = bits_acc << 1;
				if (v >= (64'd2 << ROOT_FRAC_BITS)) begin
					bits_acc = bits_acc | 64'd1;
					v        = v >> 1;
				end
			end
			log_curve[i] = bits_acc;
		end
		// Each root is the truncated square root of the one before, found bit by bit.
		root_curve[0] = 64'd2 << ROOT_FRAC_BITS;
		for (int k = 1; k <= LOG_FRAC_BITS; k++) begin
			acc = 0;
			for (int b = 31; b >= 0; b--) begin
				trial = acc | (64'd1 << b);
				if (trial * trial <= (root_curve[k-1] << ROOT_FRAC_BITS)) begin
					acc = trial;
				end
			end
			root_curve[k] = acc;
		end
	endfunction

	// sign(x) * |x|^p through log2, a multiply by p and exp2, saturated to full scale.
	function automatic companded_t compand(input logic signed [SAMPLE_BITS-1:0] smp,
			input logic signed [EXP_BITS-1:0] p);
		companded_t      res;
		logic            neg;
		longint          sv;
		longint unsigned m;
		longint unsigned idx;
		longint unsigned lim;
		longint unsigned mag;
		longint unsigned fm;
		longint          log_mag;
		longint          y;
		longint          ipart;
		longint          sh;
		int              e;
		res = '0;
		neg = smp[SAMPLE_BITS-1];
		sv  = longint'(smp);
		m   = neg ? -sv : sv;   // most negative sample gives exactly full scale
		if (m == 0) begin
			return res;
		end
		e = 0;
		for (int b = 0; b < SAMPLE_BITS; b++) begin
			if (m[b]) begin
				e = b;
			end
		end
		idx     = ((m - (64'd1 << e)) * LOG_TAB_ENTRIES) >> e;
		log_mag = longint'(e - (SAMPLE_BITS - 1)) * (longint'(1) << LOG_FRAC_BITS)
			+ longint'(log_curve[idx]);
		// Round the product half up to Q.16; arithmetic shift floors.
		y   = (log_mag * longint'(p) + (longint'(1) << (EXP_FRAC_BITS - 1))) >>> EXP_FRAC_BITS;
		lim = neg ? (64'd1 << (SAMPLE_BITS - 1)) : (64'd1 << (SAMPLE_BITS - 1)) - 1;
		if (y > 0) begin
			mag = lim + 1;                       // above full scale
		end else if (y == 0) begin
			mag = 64'd1 << (SAMPLE_BITS - 1);    // exactly full scale
		end else begin
			ipart = y >>> LOG_FRAC_BITS;
			fm    = 64'd1 << ROOT_FRAC_BITS;
			for (int k = 1; k <= LOG_FRAC_BITS; k++) begin
				if (y[LOG_FRAC_BITS-k]) begin
					fm = (fm * root_curve[k]) >> ROOT_FRAC_BITS;
				end
			end
			sh = longint'(ROOT_FRAC_BITS - (SAMPLE_BITS - 1)) - ipart;
			if (sh >= 63) begin
				mag = 0;                         // far below one LSB
			end else if (sh <= 0) begin
				mag = fm;
			end else begin
				mag = (fm + (64'd1 << (sh - 1))) >> sh;
			end
		end
		if (mag > lim) begin
			mag      = lim;
			res.clip = 1'b1;
		end
		res.value = neg ? SAMPLE_BITS'(64'd0 - mag) : SAMPLE_BITS'(mag);
		return res;
	endfunction

	function automatic void report_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("MISMATCH %0t: %s", $realtime, msg);
		end
	endfunction

	// Record each accepted request, then check each accepted result against the oldest one.
	always @(posedge clk) begin : result_check
		companded_t want;
		if (in_ch.valid && in_ch.ready) begin
			pending_outputs.push_back(compand(in_ch.sample_in, exponent_reg));
		end
		if (out_ch.valid && out_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				report_failure($sformatf("unexpected result sample_out=%0d clipped=%0b",
					out_ch.sample_out, out_ch.clipped));
			end else begin
				want = pending_outputs.pop_front();
				if (out_ch.sample_out !== want.value || out_ch.clipped !== want.clip) begin
					report_failure($sformatf("sample_out exp %0d got %0d, clipped exp %0b got %0b",
						want.value, out_ch.sample_out, want.clip, out_ch.clipped));
				end
			end
		end
	end

	// Result side backpressure: ready drops about a third of the time while gaps are on.
	always @(posedge clk) begin
		out_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 33);
	end

	// Watchdog: any request or result moving resets the count.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("power_law_compander regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one request and hold it until taken. Valid stays high on return so that
	// back-to-back requests never lower and raise it in the same step.
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		if (gaps_on) begin
			while ($urandom_range(0, 99) < 33) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= smp;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Sender holds off until every outstanding result has come back.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_outputs.size() != 0);
	endtask

	// Register writes happen only with the pipeline empty.
	task automatic write_exponent(input logic signed [EXP_BITS-1:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we       <= 1'b0;
		exponent_reg = val;
	endtask

	// Mostly magnitudes spread over every octave, some raw words and corner values.
	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		logic [SAMPLE_BITS-1:0] mag;
		int                     e;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return 1;
					2: return -1;
					3: return FULL_POS;
					default: return FULL_NEG;
				endcase
			end
			1, 2, 3: begin
				return SAMPLE_BITS'($urandom);
			end
			default: begin
				e      = $urandom_range(0, SAMPLE_BITS - 2);
				mag    = SAMPLE_BITS'($urandom) & ((SAMPLE_BITS'(1) << e) - 1'b1);
				mag[e] = 1'b1;
				return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
			end
		endcase
	endfunction

	// Exponents near the useful range most of the time, any 16-bit word otherwise.
	function automatic logic signed [EXP_BITS-1:0] random_exponent();
		if ($urandom_range(0, 2) == 0) begin
			return EXP_BITS'($urandom);
		end
		return EXP_BITS'(int'($urandom_range(0, 16384)) - 8192);
	endfunction

	// Reset exponent log10(8): zero, unit steps, both full scales, a power of two, toggled bit patterns.
	task automatic test_reset_exponent();
		send_sample('0);
		send_sample(1);
		send_sample(-1);
		send_sample(FULL_POS);
		send_sample(FULL_NEG);
		send_sample(24'sh000100);
		send_sample(-24'sh7fffff);
		send_sample(24'sh555555);
		send_sample(-24'sh2aaaab);
	endtask

	// p = 0: every nonzero magnitude maps to full scale; positive side clips,
	// negative side lands exactly on the most negative code.
	task automatic test_zero_exponent();
		write_exponent('0);
		send_sample(5);
		send_sample(-5);
		send_sample(FULL_POS);
	endtask

	// Most negative p drives results past full scale (saturation on both signs);
	// most positive p drives small inputs below one LSB, while the most negative
	// sample still has log zero and stays at full scale.
	task automatic test_extreme_exponents();
		write_exponent(EXP_MIN);
		send_sample(1);
		send_sample(-1);
		send_sample(24'sh400000);
		send_sample(FULL_NEG);
		write_exponent(EXP_MAX);
		send_sample(1);
		send_sample(-1);
		send_sample(FULL_POS);
		send_sample(FULL_NEG);
	endtask

	// p = 1.0: near identity, exercises the root chain with mixed fraction bits.
	task automatic test_unity_exponent();
		write_exponent(EXP_UNITY);
		send_sample(24'sh123456);
		send_sample(-24'sh654321);
	endtask

	// Several exponent settings, extremes first, each with a batch of random requests.
	task automatic test_random_exponents();
		logic signed [EXP_BITS-1:0] p;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: p = EXP_MAX;
				1: p = EXP_MIN;
				2: p = CFG_EXP_RESET;
				default: p = random_exponent();
			endcase
			write_exponent(p);
			repeat (55) send_sample(random_sample());
		end
	endtask

	// Full rate on both sides: no idle cycles and no backpressure.
	task automatic test_unbroken_stream();
		write_exponent(random_exponent());
		gaps_on = 1'b0;
		repeat (100) send_sample(random_sample());
		gaps_on = 1'b1;
	endtask

	// Bursts separated by a full drain of the pipeline.
	task automatic test_paused_sender();
		repeat (3) begin
			repeat (20) send_sample(random_sample());
			wait_drained();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		build_curve_tables();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_exponent();
		test_zero_exponent();
		test_extreme_exponents();
		test_unity_exponent();
		test_random_exponents();
		test_unbroken_stream();
		test_paused_sender();

		// Let the pipeline empty, then watch a little longer for stray results.
		wait_drained();
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		mismatch_count += pending_outputs.size();
		if (mismatch_count == 0) begin
			$display("power_law_compander regression: pass");
		end else begin
			$display("power_law_compander regression: fail");
		end
		$finish;
	end

endmodule

### power_law_compander.f
hdl/plc_pkg.sv
hdl/plc_if.sv
hdl/plc_log.sv
hdl/plc_scale.sv
hdl/plc_exp.sv
hdl/power_law_compander.sv
dv/power_law_compander_tb.sv
